@@ rtl/bgfl_pkg.sv @@
// ----------------------------------------------------------------------------
// bgfl_pkg
// Shared types and constants of the battery guard fault latch: sample and
// result records, timer/latch state, register indexes and reset values.
// ----------------------------------------------------------------------------
package bgfl_pkg;

   // register indexes of the configuration port
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SOFT_THRESHOLD  = 4'd0,
      CSR_HARD_THRESHOLD  = 4'd1,
      CSR_STOP_THRESHOLD  = 4'd2,
      CSR_RELEASE_MARGIN  = 4'd3,
      CSR_DISCHARGE_LIMIT = 4'd4,
      CSR_DEBOUNCE_TIMES  = 4'd5,
      CSR_CEILING_CAPS    = 4'd6,
      CSR_TEMP_LIMITS     = 4'd7
   } csr_addr_type;

   // register reset values
   localparam logic [15:0] SOFT_THRESHOLD_RST  = 16'd11800;
   localparam logic [15:0] HARD_THRESHOLD_RST  = 16'd11400;
   localparam logic [15:0] STOP_THRESHOLD_RST  = 16'd11000;
   localparam logic [15:0] RELEASE_MARGIN_RST  = 16'd300;
   localparam logic [16:0] DISCHARGE_LIMIT_RST = 17'd20000;
   localparam logic [31:0] DEBOUNCE_TIMES_RST  = 32'd65538000;
   localparam logic [20:0] CEILING_CAPS_RST    = 21'd824390;
   localparam logic [23:0] TEMP_LIMITS_RST     = 24'd3943685;

   // fault mask bit positions
   localparam int FAULT_SOFT   = 0;
   localparam int FAULT_HARD   = 1;
   localparam int FAULT_STOP   = 2;
   localparam int FAULT_OVERCUR = 3;
   localparam int FAULT_FREEZE = 4;
   localparam int FAULT_TEMP   = 5;

   localparam logic [6:0]         CEILING_DEFAULT  = 7'd100;
   localparam logic signed [15:0] FREEZE_POWER_DW  = 16'sd10;
   localparam logic [15:0]        TIMER_MAX        = 16'hFFFF;

   typedef struct packed {
      logic               sample_valid;
      logic [15:0]        voltage_mv;
      logic signed [17:0] current_ma;
      logic               temp_present;
      logic signed [7:0]  temp_degc;
      logic signed [15:0] power_dw;
      logic [15:0]        dt_ms;
   } sample_type;

   typedef struct packed {
      logic [5:0] fault_mask;
      logic [6:0] power_limit_pct;
      logic       stop_request;
   } result_type;

   // one debounce stage: timer of its fault condition and its latch
   typedef struct packed {
      logic [15:0] timer;
      logic        latch;
   } stage_type;

   // current latch view handed to the policy block
   typedef struct packed {
      logic soft_sag;
      logic hard_sag;
      logic stop_sag;
      logic overcur;
   } latches_type;

endpackage

@@ rtl/bgfl_if.sv @@
// ----------------------------------------------------------------------------
// bgfl channel interfaces
// Valid/ready channels of the battery guard: sample requests, results and
// register writes.
// ----------------------------------------------------------------------------
interface bgfl_req_if;
   logic               valid;
   logic               ready;
   logic               sample_valid;
   logic [15:0]        voltage_mv;
   logic signed [17:0] current_ma;
   logic               temp_present;
   logic signed [7:0]  temp_degc;
   logic signed [15:0] power_dw;
   logic [15:0]        dt_ms;

   modport source (output valid, output sample_valid, output voltage_mv,
                   output current_ma, output temp_present, output temp_degc,
                   output power_dw, output dt_ms, input ready);
   modport sink   (input valid, input sample_valid, input voltage_mv,
                   input current_ma, input temp_present, input temp_degc,
                   input power_dw, input dt_ms, output ready);
endinterface

interface bgfl_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] fault_mask;
   logic [6:0] power_limit_pct;
   logic       stop_request;

   modport source (output valid, output fault_mask, output power_limit_pct,
                   output stop_request, input ready);
   modport sink   (input valid, input fault_mask, input power_limit_pct,
                   input stop_request, output ready);
endinterface

interface bgfl_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  addr;
   logic [31:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/battery_guard_fault_latch.sv @@
// ----------------------------------------------------------------------------
// battery_guard_fault_latch
// Battery sample guard with debounced sag and over-discharge fault latches.
// ----------------------------------------------------------------------------
// One request carries one battery sample and gives exactly one result. The
// block takes a request in every cycle and offers its result on rsp once the
// sample has passed the sample register and the result register: the sample
// register feeds the timer/latch update and fault policy, whose outcome lands
// in the result register, while the four stage timers and latches update in
// the same cycle. A result waiting on a stalled rsp side holds the sample
// register, which stalls req. Register writes are always taken (csr ready is
// tied high) and must only happen while no request is in flight. Invalid
// samples leave the timers and latches alone.
// ----------------------------------------------------------------------------
module battery_guard_fault_latch (
   input  logic              clock,
   input  logic              reset,
   bgfl_req_if.sink          req_chan,
   bgfl_rsp_if.source        rsp_chan,
   bgfl_csr_if.sink          csr_chan
);

   // configuration registers
   logic [15:0] soft_thr_ff;
   logic [15:0] hard_thr_ff;
   logic [15:0] stop_thr_ff;
   logic [15:0] margin_ff;
   logic [16:0] limit_ff;
   logic [31:0] debounce_ff;
   logic [20:0] caps_ff;
   logic [23:0] tlimits_ff;

   // pipeline registers
   logic                  s1_valid_ff;
   bgfl_pkg::sample_type  s1_sample_ff;
   bgfl_pkg::sample_type  s1_sample_in;
   logic                  rsp_valid_ff;
   bgfl_pkg::result_type  rsp_ff;
   bgfl_pkg::result_type  rsp_in;

   // stage state
   bgfl_pkg::stage_type soft_ff, hard_ff, stop_ff, overcur_ff;
   bgfl_pkg::stage_type soft_in, hard_in, stop_in, overcur_in;

   logic s1_advance;
   logic req_take;

   logic [16:0] voltage_x;
   logic [16:0] soft_rel, hard_rel, stop_rel;
   logic [17:0] discharge;
   logic [20:0] discharge_x5;
   logic [20:0] limit_x4;
   logic        overcur_active;
   logic        overcur_release;

   bgfl_pkg::latches_type latches;

   // handshake
   assign s1_advance     = s1_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_valid_ff | s1_advance;
   assign req_take       = req_chan.valid & req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign s1_sample_in.sample_valid  = req_chan.sample_valid;
   assign s1_sample_in.voltage_mv    = req_chan.voltage_mv;
   assign s1_sample_in.current_ma    = req_chan.current_ma;
   assign s1_sample_in.temp_present  = req_chan.temp_present;
   assign s1_sample_in.temp_degc     = req_chan.temp_degc;
   assign s1_sample_in.power_dw      = req_chan.power_dw;
   assign s1_sample_in.dt_ms         = req_chan.dt_ms;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         soft_thr_ff <= bgfl_pkg::SOFT_THRESHOLD_RST;
         hard_thr_ff <= bgfl_pkg::HARD_THRESHOLD_RST;
         stop_thr_ff <= bgfl_pkg::STOP_THRESHOLD_RST;
         margin_ff   <= bgfl_pkg::RELEASE_MARGIN_RST;
         limit_ff    <= bgfl_pkg::DISCHARGE_LIMIT_RST;
         debounce_ff <= bgfl_pkg::DEBOUNCE_TIMES_RST;
         caps_ff     <= bgfl_pkg::CEILING_CAPS_RST;
         tlimits_ff  <= bgfl_pkg::TEMP_LIMITS_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            bgfl_pkg::CSR_SOFT_THRESHOLD:  soft_thr_ff <= csr_chan.data[15:0];
            bgfl_pkg::CSR_HARD_THRESHOLD:  hard_thr_ff <= csr_chan.data[15:0];
            bgfl_pkg::CSR_STOP_THRESHOLD:  stop_thr_ff <= csr_chan.data[15:0];
            bgfl_pkg::CSR_RELEASE_MARGIN:  margin_ff   <= csr_chan.data[15:0];
            bgfl_pkg::CSR_DISCHARGE_LIMIT: limit_ff    <= csr_chan.data[16:0];
            bgfl_pkg::CSR_DEBOUNCE_TIMES:  debounce_ff <= csr_chan.data;
            bgfl_pkg::CSR_CEILING_CAPS:    caps_ff     <= csr_chan.data[20:0];
            bgfl_pkg::CSR_TEMP_LIMITS:     tlimits_ff  <= csr_chan.data[23:0];
            default: ;
         endcase
      end
   end

   // sag conditions, release sums kept at 17 bits
   assign voltage_x = {1'b0, s1_sample_ff.voltage_mv};
   assign soft_rel  = {1'b0, soft_thr_ff} + {1'b0, margin_ff};
   assign hard_rel  = {1'b0, hard_thr_ff} + {1'b0, margin_ff};
   assign stop_rel  = {1'b0, stop_thr_ff} + {1'b0, margin_ff};

   // discharge magnitude, zero while charging
   assign discharge = s1_sample_ff.current_ma[17]
                      ? (~s1_sample_ff.current_ma + 18'd1) : 18'd0;
   assign overcur_active  = discharge > {1'b0, limit_ff};
   assign discharge_x5    = {1'b0, discharge, 2'b00} + {3'b000, discharge};
   assign limit_x4        = {2'b00, limit_ff, 2'b00};
   assign overcur_release = discharge_x5 < limit_x4;

   bgfl_timer_latch u_soft (
      .active      (s1_sample_ff.voltage_mv < soft_thr_ff),
      .release_ok  (voltage_x >= soft_rel),
      .dt_ms       (s1_sample_ff.dt_ms),
      .debounce_ms (debounce_ff[15:0]),
      .cur         (soft_ff),
      .nxt         (soft_in)
   );

   bgfl_timer_latch u_hard (
      .active      (s1_sample_ff.voltage_mv < hard_thr_ff),
      .release_ok  (voltage_x >= hard_rel),
      .dt_ms       (s1_sample_ff.dt_ms),
      .debounce_ms (debounce_ff[15:0]),
      .cur         (hard_ff),
      .nxt         (hard_in)
   );

   bgfl_timer_latch u_stop (
      .active      (s1_sample_ff.voltage_mv < stop_thr_ff),
      .release_ok  (voltage_x >= stop_rel),
      .dt_ms       (s1_sample_ff.dt_ms),
      .debounce_ms (debounce_ff[15:0]),
      .cur         (stop_ff),
      .nxt         (stop_in)
   );

   bgfl_timer_latch u_overcur (
      .active      (overcur_active),
      .release_ok  (overcur_release),
      .dt_ms       (s1_sample_ff.dt_ms),
      .debounce_ms (debounce_ff[31:16]),
      .cur         (overcur_ff),
      .nxt         (overcur_in)
   );

   // the result sees the updated latches
   assign latches.soft_sag = soft_in.latch;
   assign latches.hard_sag = hard_in.latch;
   assign latches.stop_sag = stop_in.latch;
   assign latches.overcur  = overcur_in.latch;

   bgfl_policy u_policy (
      .sample       (s1_sample_ff),
      .latches      (latches),
      .ceiling_caps (caps_ff),
      .temp_limits  (tlimits_ff),
      .result       (rsp_in)
   );

   // stage state, updated by valid samples only
   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff    <= '0;
         hard_ff    <= '0;
         stop_ff    <= '0;
         overcur_ff <= '0;
      end else if (s1_advance && s1_sample_ff.sample_valid) begin
         soft_ff    <= soft_in;
         hard_ff    <= hard_in;
         stop_ff    <= stop_in;
         overcur_ff <= overcur_in;
      end
   end

   // sample register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= s1_sample_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.fault_mask      = rsp_ff.fault_mask;
   assign rsp_chan.power_limit_pct = rsp_ff.power_limit_pct;
   assign rsp_chan.stop_request    = rsp_ff.stop_request;

endmodule

@@ rtl/bgfl_timer_latch.sv @@
// ----------------------------------------------------------------------------
// bgfl_timer_latch
// Next state of one debounce stage: saturating millisecond timer that runs
// while the condition holds, latch set at debounce, released on hysteresis.
// ----------------------------------------------------------------------------
module bgfl_timer_latch (
   input  logic                 active,
   input  logic                 release_ok,
   input  logic [15:0]          dt_ms,
   input  logic [15:0]          debounce_ms,
   input  bgfl_pkg::stage_type  cur,
   output bgfl_pkg::stage_type  nxt
);

   logic [16:0] sum;
   logic [15:0] sat;

   // saturating timer add
   assign sum = {1'b0, cur.timer} + {1'b0, dt_ms};
   assign sat = sum[16] ? bgfl_pkg::TIMER_MAX : sum[15:0];

   // run and set, or clear and maybe release
   always_comb begin
      if (active) begin
         nxt.timer = sat;
         nxt.latch = cur.latch | (sat >= debounce_ms);
      end else begin
         nxt.timer = '0;
         nxt.latch = cur.latch & ~release_ok;
      end
   end

endmodule

@@ rtl/bgfl_policy.sv @@
// ----------------------------------------------------------------------------
// bgfl_policy
// Forms the fault mask, power ceiling and stop flag of one sample from the
// updated latches and the temperature policy.
// ----------------------------------------------------------------------------
module bgfl_policy (
   input  bgfl_pkg::sample_type   sample,
   input  bgfl_pkg::latches_type  latches,
   input  logic [20:0]            ceiling_caps,
   input  logic [23:0]            temp_limits,
   output bgfl_pkg::result_type   result
);

   logic [6:0]        soft_cap;
   logic [6:0]        hard_cap;
   logic [6:0]        temp_cap;
   logic signed [7:0] cold_c;
   logic signed [7:0] hot_c;
   logic signed [7:0] tstop_c;

   assign soft_cap = ceiling_caps[6:0];
   assign hard_cap = ceiling_caps[13:7];
   assign temp_cap = ceiling_caps[20:14];
   assign cold_c   = signed'(temp_limits[7:0]);
   assign hot_c    = signed'(temp_limits[15:8]);
   assign tstop_c  = signed'(temp_limits[23:16]);

   // caps only ever lower the ceiling
   always_comb begin
      logic [5:0] faults;
      logic [6:0] ceiling;
      logic       stop;
      faults  = '0;
      ceiling = bgfl_pkg::CEILING_DEFAULT;
      stop    = 1'b0;
      if (latches.soft_sag) begin
         faults[bgfl_pkg::FAULT_SOFT] = 1'b1;
         if (ceiling > soft_cap) ceiling = soft_cap;
      end
      if (latches.hard_sag) begin
         faults[bgfl_pkg::FAULT_HARD] = 1'b1;
         if (ceiling > hard_cap) ceiling = hard_cap;
      end
      if (latches.stop_sag) begin
         faults[bgfl_pkg::FAULT_STOP] = 1'b1;
         stop = 1'b1;
      end
      // overcurrent shares the hard cap
      if (latches.overcur) begin
         faults[bgfl_pkg::FAULT_OVERCUR] = 1'b1;
         if (ceiling > hard_cap) ceiling = hard_cap;
      end
      // temperature policy, only with a sensor reporting
      if (sample.temp_present) begin
         if (sample.temp_degc <= 8'sd0 && sample.power_dw > bgfl_pkg::FREEZE_POWER_DW)
            faults[bgfl_pkg::FAULT_FREEZE] = 1'b1;
         if (sample.temp_degc >= tstop_c) begin
            faults[bgfl_pkg::FAULT_TEMP] = 1'b1;
            stop = 1'b1;
         end else if (sample.temp_degc < cold_c || sample.temp_degc > hot_c) begin
            faults[bgfl_pkg::FAULT_TEMP] = 1'b1;
            if (ceiling > temp_cap) ceiling = temp_cap;
         end
      end
      // invalid sample gives the default result
      if (sample.sample_valid) begin
         result.fault_mask      = faults;
         result.power_limit_pct = ceiling;
         result.stop_request    = stop;
      end else begin
         result.fault_mask      = '0;
         result.power_limit_pct = bgfl_pkg::CEILING_DEFAULT;
         result.stop_request    = 1'b0;
      end
   end

endmodule

@@ tb/sv/battery_guard_fault_latch_tb.sv @@
// ----------------------------------------------------------------------------
// battery_guard_fault_latch_tb
// Self-checking bench for the battery guard fault latch. A scoreboard class
// keeps its own copy of the registers, the stage timers and the latches. It
// works out the fault mask, the power ceiling and the stop flag of every
// accepted sample request and compares them in order with the results that
// come back. Directed samples cover the edges of the sag, over-discharge and
// temperature rules. Random runs of samples held near the thresholds follow
// under several register settings, with random idling on both sides and one
// long result stall.
// ----------------------------------------------------------------------------
module battery_guard_fault_latch_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 185;
   localparam int HOLD_PHASE       = 6;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 200000;

   // kinds of register setting used by the random phases
   typedef enum int {
      SET_RESET,
      SET_PLAUSIBLE,
      SET_ALL_ZERO,
      SET_ALL_ONES,
      SET_NOISE
   } setting_kind_type;

   // ---------------------------------------------------------------------
   // fault predictor and store of expected results
   // ---------------------------------------------------------------------
   class fault_latch_scoreboard;
      logic [15:0] soft_thr, hard_thr, stop_thr, margin;
      logic [16:0] discharge_limit;
      logic [31:0] debounce;
      logic [20:0] caps;
      logic [23:0] temp_limits;
      logic [15:0] soft_ms, hard_ms, stop_ms, oc_ms;
      bit          soft_latched, hard_latched, stop_latched, oc_latched;
      bgfl_pkg::result_type expected_q [$];
      int          mismatches;
      int          noted;
      int          checked;

      function new();
         soft_thr        = bgfl_pkg::SOFT_THRESHOLD_RST;
         hard_thr        = bgfl_pkg::HARD_THRESHOLD_RST;
         stop_thr        = bgfl_pkg::STOP_THRESHOLD_RST;
         margin          = bgfl_pkg::RELEASE_MARGIN_RST;
         discharge_limit = bgfl_pkg::DISCHARGE_LIMIT_RST;
         debounce        = bgfl_pkg::DEBOUNCE_TIMES_RST;
         caps            = bgfl_pkg::CEILING_CAPS_RST;
         temp_limits     = bgfl_pkg::TEMP_LIMITS_RST;
         soft_ms         = '0;
         hard_ms         = '0;
         stop_ms         = '0;
         oc_ms           = '0;
         soft_latched    = 1'b0;
         hard_latched    = 1'b0;
         stop_latched    = 1'b0;
         oc_latched      = 1'b0;
         mismatches      = 0;
         noted           = 0;
         checked         = 0;
      endfunction

      function void write_register(logic [3:0] idx, logic [31:0] val);
         case (idx)
            bgfl_pkg::CSR_SOFT_THRESHOLD:  soft_thr        = val[15:0];
            bgfl_pkg::CSR_HARD_THRESHOLD:  hard_thr        = val[15:0];
            bgfl_pkg::CSR_STOP_THRESHOLD:  stop_thr        = val[15:0];
            bgfl_pkg::CSR_RELEASE_MARGIN:  margin          = val[15:0];
            bgfl_pkg::CSR_DISCHARGE_LIMIT: discharge_limit = val[16:0];
            bgfl_pkg::CSR_DEBOUNCE_TIMES:  debounce        = val;
            bgfl_pkg::CSR_CEILING_CAPS:    caps            = val[20:0];
            bgfl_pkg::CSR_TEMP_LIMITS:     temp_limits     = val[23:0];
            default: ;
         endcase
      endfunction

      // millisecond timer that sticks at its maximum
      function logic [15:0] sat_ms(logic [15:0] acc, logic [15:0] dt);
         logic [16:0] sum;
         sum = {1'b0, acc} + {1'b0, dt};
         return sum[16] ? bgfl_pkg::TIMER_MAX : sum[15:0];
      endfunction

      // one voltage sag stage: debounce to set, hysteresis to release
      function void step_sag(logic [15:0] v, logic [15:0] dt, logic [15:0] thr,
                             inout logic [15:0] timer, inout bit latched);
         if (v < thr) begin
            timer = sat_ms(timer, dt);
            if (timer >= debounce[15:0])
               latched = 1'b1;
         end else begin
            timer = '0;
            if (latched && ({1'b0, v} >= {1'b0, thr} + {1'b0, margin}))
               latched = 1'b0;
         end
      endfunction

      function bgfl_pkg::result_type predict(bgfl_pkg::sample_type s);
         bgfl_pkg::result_type r;
         logic [17:0]       mag;
         logic signed [17:0] cur;
         logic signed [7:0] t, cold, hot, t_stop;
         logic signed [15:0] pw;
         logic [6:0]        soft_cap, hard_cap, temp_cap;
         int                dis;
         r.fault_mask      = '0;
         r.power_limit_pct = bgfl_pkg::CEILING_DEFAULT;
         r.stop_request    = 1'b0;
         // an invalid sample leaves all state alone
         if (!s.sample_valid)
            return r;
         soft_cap = caps[6:0];
         hard_cap = caps[13:7];
         temp_cap = caps[20:14];

         // sag stages
         step_sag(s.voltage_mv, s.dt_ms, soft_thr, soft_ms, soft_latched);
         step_sag(s.voltage_mv, s.dt_ms, hard_thr, hard_ms, hard_latched);
         step_sag(s.voltage_mv, s.dt_ms, stop_thr, stop_ms, stop_latched);
         if (soft_latched) begin
            r.fault_mask[bgfl_pkg::FAULT_SOFT] = 1'b1;
            if (r.power_limit_pct > soft_cap) r.power_limit_pct = soft_cap;
         end
         if (hard_latched) begin
            r.fault_mask[bgfl_pkg::FAULT_HARD] = 1'b1;
            if (r.power_limit_pct > hard_cap) r.power_limit_pct = hard_cap;
         end
         if (stop_latched) begin
            r.fault_mask[bgfl_pkg::FAULT_STOP] = 1'b1;
            r.stop_request = 1'b1;
         end

         // over-discharge stage, released below 0.8 of the limit
         cur = s.current_ma;
         if (cur < 0) mag = -cur;
         else mag = '0;
         dis = mag;
         if (mag > discharge_limit) begin
            oc_ms = sat_ms(oc_ms, s.dt_ms);
            if (oc_ms >= debounce[31:16])
               oc_latched = 1'b1;
         end else begin
            oc_ms = '0;
            if (oc_latched && (5 * dis < 4 * int'(discharge_limit)))
               oc_latched = 1'b0;
         end
         if (oc_latched) begin
            r.fault_mask[bgfl_pkg::FAULT_OVERCUR] = 1'b1;
            if (r.power_limit_pct > hard_cap) r.power_limit_pct = hard_cap;
         end

         // temperature policy, only with a sensor present
         if (s.temp_present) begin
            t      = s.temp_degc;
            pw     = s.power_dw;
            cold   = temp_limits[7:0];
            hot    = temp_limits[15:8];
            t_stop = temp_limits[23:16];
            if (t <= 0 && pw > bgfl_pkg::FREEZE_POWER_DW)
               r.fault_mask[bgfl_pkg::FAULT_FREEZE] = 1'b1;
            if (t >= t_stop) begin
               r.fault_mask[bgfl_pkg::FAULT_TEMP] = 1'b1;
               r.stop_request = 1'b1;
            end else if (t < cold || t > hot) begin
               r.fault_mask[bgfl_pkg::FAULT_TEMP] = 1'b1;
               if (r.power_limit_pct > temp_cap) r.power_limit_pct = temp_cap;
            end
         end
         return r;
      endfunction

      function void note_request(bgfl_pkg::sample_type s);
         expected_q.push_back(predict(s));
         noted++;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string what, int got_v, int want_v);
         $display("%0t ns mismatch: %s: got %0d, expected %0d", $time, what, got_v, want_v);
         mismatches++;
      endtask

      task check_result(bgfl_pkg::result_type got);
         bgfl_pkg::result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no request outstanding, fault mask",
                            got.fault_mask, -1);
         end else begin
            want = expected_q.pop_front();
            checked++;
            if (got.fault_mask !== want.fault_mask)
               report_mismatch("fault_mask", got.fault_mask, want.fault_mask);
            if (got.power_limit_pct !== want.power_limit_pct)
               report_mismatch("power_limit_pct", got.power_limit_pct,
                               want.power_limit_pct);
            if (got.stop_request !== want.stop_request)
               report_mismatch("stop_request", got.stop_request, want.stop_request);
         end
      endtask
   endclass

   // ---------------------------------------------------------------------
   // clock, channels and block
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   bgfl_req_if req_bus ();
   bgfl_rsp_if rsp_bus ();
   bgfl_csr_if csr_bus ();

   fault_latch_scoreboard sb = new();

   bit sender_idle_en   = 1'b1;
   bit receiver_idle_en = 1'b1;
   bit hold_request     = 1'b0;
   int cycle_count      = 0;
   int settings_applied = 0;

   battery_guard_fault_latch i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // helpers for building samples
   // ---------------------------------------------------------------------
   function int clamp(int x, int lo, int hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function bgfl_pkg::sample_type make_sample(bit valid, int v, int cur, bit tp, int t,
                                              int p, int dt);
      bgfl_pkg::sample_type s;
      s.sample_valid  = valid;
      s.voltage_mv    = 16'(v);
      s.current_ma    = 18'(cur);
      s.temp_present  = tp;
      s.temp_degc     = 8'(t);
      s.power_dw      = 16'(p);
      s.dt_ms         = 16'(dt);
      return s;
   endfunction

   // run level for the voltage: mostly around a threshold and its release point
   function int pick_voltage();
      int thr;
      int span;
      case ($urandom_range(0, 2))
         0:       thr = sb.soft_thr;
         1:       thr = sb.hard_thr;
         default: thr = sb.stop_thr;
      endcase
      span = clamp(int'(sb.margin), 0, 2000);
      case ($urandom_range(0, 9))
         6:       return 0;
         7:       return 65535;
         8, 9:    return int'($urandom_range(0, 65535));
         default: return clamp(thr - 200 + int'($urandom_range(0, span + 400)), 0, 65535);
      endcase
   endfunction

   // run level for the current: mostly discharge around the limit
   function int pick_current();
      int lim;
      lim = sb.discharge_limit;
      case ($urandom_range(0, 9))
         5:       return -131072;
         6:       return 131071;
         7, 8, 9: return int'($urandom_range(0, 262143)) - 131072;
         default: return -(lim * int'($urandom_range(60, 140)) / 100);
      endcase
   endfunction

   function bgfl_pkg::sample_type random_sample(int base_v, int base_i);
      bgfl_pkg::sample_type s;
      int         deb;
      int         t_ref;
      s.sample_valid = ($urandom_range(0, 11) != 0);
      if ($urandom_range(0, 6) != 0)
         s.voltage_mv = 16'(clamp(base_v + int'($urandom_range(0, 80)) - 40, 0, 65535));
      else
         s.voltage_mv = 16'($urandom());
      if ($urandom_range(0, 6) != 0)
         s.current_ma = 18'(clamp(base_i + int'($urandom_range(0, 400)) - 200,
                                  -131072, 131071));
      else
         s.current_ma = 18'($urandom());
      s.temp_present = ($urandom_range(0, 4) != 0);
      // temperature near one of the limits or anywhere
      case ($urandom_range(0, 7))
         0:       t_ref = int'($signed(sb.temp_limits[7:0]));
         1:       t_ref = int'($signed(sb.temp_limits[15:8]));
         2:       t_ref = int'($signed(sb.temp_limits[23:16]));
         3:       t_ref = 0;
         default: t_ref = int'($signed(8'($urandom())));
      endcase
      s.temp_degc = 8'(clamp(t_ref + int'($urandom_range(0, 6)) - 3, -128, 127));
      if ($urandom_range(0, 3) == 0)
         s.power_dw = 16'(8 + int'($urandom_range(0, 4)));
      else
         s.power_dw = 16'($urandom());
      // time steps mostly short against the debounce times
      deb = $urandom_range(0, 1) ? int'(sb.debounce[15:0]) : int'(sb.debounce[31:16]);
      case ($urandom_range(0, 9))
         0:       s.dt_ms = '0;
         1:       s.dt_ms = 16'($urandom());
         2:       s.dt_ms = bgfl_pkg::TIMER_MAX;
         default: s.dt_ms = 16'($urandom_range(0, deb / 3 + 2));
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   task send_sample(input bgfl_pkg::sample_type s);
      if (sender_idle_en && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sample_valid  <= s.sample_valid;
      req_bus.voltage_mv    <= s.voltage_mv;
      req_bus.current_ma    <= s.current_ma;
      req_bus.temp_present  <= s.temp_present;
      req_bus.temp_degc     <= s.temp_degc;
      req_bus.power_dw      <= s.power_dw;
      req_bus.dt_ms         <= s.dt_ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(s);
   endtask

   // write channel stays high across back-to-back writes; caller lowers it
   task write_csr(input logic [3:0] idx, input logic [31:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_register(idx, val);
   endtask

   task wait_results_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task configure_phase(input setting_kind_type kind);
      logic [31:0] vals [8];
      int          stop_mv;
      int          hard_mv;
      int          i;
      case (kind)
         SET_RESET: begin
            vals[bgfl_pkg::CSR_SOFT_THRESHOLD]  = 32'(bgfl_pkg::SOFT_THRESHOLD_RST);
            vals[bgfl_pkg::CSR_HARD_THRESHOLD]  = 32'(bgfl_pkg::HARD_THRESHOLD_RST);
            vals[bgfl_pkg::CSR_STOP_THRESHOLD]  = 32'(bgfl_pkg::STOP_THRESHOLD_RST);
            vals[bgfl_pkg::CSR_RELEASE_MARGIN]  = 32'(bgfl_pkg::RELEASE_MARGIN_RST);
            vals[bgfl_pkg::CSR_DISCHARGE_LIMIT] = 32'(bgfl_pkg::DISCHARGE_LIMIT_RST);
            vals[bgfl_pkg::CSR_DEBOUNCE_TIMES]  = bgfl_pkg::DEBOUNCE_TIMES_RST;
            vals[bgfl_pkg::CSR_CEILING_CAPS]    = 32'(bgfl_pkg::CEILING_CAPS_RST);
            vals[bgfl_pkg::CSR_TEMP_LIMITS]     = 32'(bgfl_pkg::TEMP_LIMITS_RST);
         end
         SET_ALL_ZERO: begin
            for (i = 0; i <= int'(bgfl_pkg::CSR_TEMP_LIMITS); i++) vals[i] = '0;
         end
         SET_ALL_ONES: begin
            for (i = 0; i <= int'(bgfl_pkg::CSR_TEMP_LIMITS); i++) vals[i] = '1;
         end
         SET_NOISE: begin
            for (i = 0; i <= int'(bgfl_pkg::CSR_TEMP_LIMITS); i++) vals[i] = $urandom();
         end
         default: begin
            // ordered thresholds near a 12 V pack, short debounce times
            stop_mv = $urandom_range(9000, 12000);
            hard_mv = stop_mv + int'($urandom_range(0, 800));
            vals[bgfl_pkg::CSR_STOP_THRESHOLD]  = 32'(stop_mv);
            vals[bgfl_pkg::CSR_HARD_THRESHOLD]  = 32'(hard_mv);
            vals[bgfl_pkg::CSR_SOFT_THRESHOLD]  =
               32'(hard_mv + int'($urandom_range(0, 800)));
            vals[bgfl_pkg::CSR_RELEASE_MARGIN]  = $urandom_range(0, 600);
            vals[bgfl_pkg::CSR_DISCHARGE_LIMIT] = $urandom_range(1000, 40000);
            vals[bgfl_pkg::CSR_DEBOUNCE_TIMES]  = {16'($urandom_range(0, 400)),
                                                   16'($urandom_range(0, 400))};
            vals[bgfl_pkg::CSR_CEILING_CAPS]    = $urandom_range(0, 21'h1FFFFF);
            vals[bgfl_pkg::CSR_TEMP_LIMITS]     = {8'(int'($urandom_range(40, 90))),
                                                   8'(int'($urandom_range(30, 60))),
                                                   8'(int'($urandom_range(0, 30)) - 20)};
         end
      endcase
      for (i = 0; i <= int'(bgfl_pkg::CSR_TEMP_LIMITS); i++) write_csr(4'(i), vals[i]);
      // an index past the last register must change nothing
      if ($urandom_range(0, 1))
         write_csr(4'(bgfl_pkg::CSR_TEMP_LIMITS) + 4'($urandom_range(1, 8)), $urandom());
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   // edges of each rule under the reset settings, then zero debounce
   task run_directed();
      send_sample(make_sample(0, 0, -131072, 1, 127, 32767, 65535));
      send_sample(make_sample(1, 12500, 1000, 1, 25, 0, 100));
      // just short of the sag debounce, then a saturating step
      send_sample(make_sample(1, 10000, 0, 0, -128, 0, 1999));
      send_sample(make_sample(1, 10000, 0, 0, 0, 0, 65535));
      send_sample(make_sample(1, 10000, 0, 0, 0, 0, 65535));
      send_sample(make_sample(0, 65535, 131071, 0, 0, 0, 65535));
      // release of the stop and soft sag latches exactly at threshold plus margin
      send_sample(make_sample(1, 11200, 0, 0, 0, 0, 0));
      send_sample(make_sample(1, 11300, 0, 0, 0, 0, 0));
      send_sample(make_sample(1, 12099, 0, 0, 0, 0, 0));
      send_sample(make_sample(1, 12100, 0, 0, 0, 0, 0));
      // over-discharge set, hold at exactly 0.8 of the limit, release below
      send_sample(make_sample(1, 65535, -131072, 0, 0, 0, 1000));
      send_sample(make_sample(1, 65535, -16000, 0, 0, 0, 10));
      send_sample(make_sample(1, 65535, -15999, 0, 0, 0, 10));
      // charging below freezing and the temperature bands
      send_sample(make_sample(1, 12500, 131071, 1, 0, 11, 0));
      send_sample(make_sample(1, 12500, 0, 1, -128, 32767, 0));
      send_sample(make_sample(1, 12500, 0, 1, 1, 10, 0));
      send_sample(make_sample(1, 12500, 0, 1, 60, -32768, 0));
      send_sample(make_sample(1, 12500, 0, 1, 46, 0, 0));
      send_sample(make_sample(1, 12500, 0, 1, 127, 0, 0));
      send_sample(make_sample(1, 12500, 0, 0, 127, 32767, 0));
      // zero debounce and caps above one hundred
      wait_results_drained();
      write_csr(bgfl_pkg::CSR_DEBOUNCE_TIMES, '0);
      write_csr(bgfl_pkg::CSR_CEILING_CAPS, 32'h001F_FFFF);
      csr_bus.valid <= 1'b0;
      send_sample(make_sample(1, 0, -20001, 1, 45, 0, 0));
      send_sample(make_sample(1, 11000, -20000, 1, 5, 0, 0));
   endtask

   task send_random_run(input int len);
      int base_v;
      int base_i;
      int k;
      base_v = pick_voltage();
      base_i = pick_current();
      for (k = 0; k < len; k++) send_sample(random_sample(base_v, base_i));
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls and one long hold-off
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare every accepted result
   always @(posedge clock) begin : result_monitor
      bgfl_pkg::result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.fault_mask      = rsp_bus.fault_mask;
         got.power_limit_pct = rsp_bus.power_limit_pct;
         got.stop_request    = rsp_bus.stop_request;
         sb.check_result(got);
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("[battery_guard_fault_latch] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      setting_kind_type plan [PHASES];
      int phase;
      int sent;
      int run_len;
      plan = '{SET_RESET, SET_PLAUSIBLE, SET_ALL_ZERO, SET_ALL_ONES, SET_NOISE,
               SET_PLAUSIBLE, SET_PLAUSIBLE, SET_PLAUSIBLE};
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.sample_valid  <= 1'b0;
      req_bus.voltage_mv    <= '0;
      req_bus.current_ma    <= '0;
      req_bus.temp_present  <= 1'b0;
      req_bus.temp_degc     <= '0;
      req_bus.power_dw      <= '0;
      req_bus.dt_ms         <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.addr          <= '0;
      csr_bus.data          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (phase = 0; phase < PHASES; phase++) begin
         wait_results_drained();
         configure_phase(plan[phase]);
         // no idling in the last phase
         sender_idle_en   = (phase != PHASES - 1);
         receiver_idle_en = (phase != PHASES - 1);
         if (phase == HOLD_PHASE)
            hold_request = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            run_len = $urandom_range(1, 12);
            if (run_len > ITEMS_PER_PHASE - sent)
               run_len = ITEMS_PER_PHASE - sent;
            send_random_run(run_len);
            sent += run_len;
         end
      end

      wait_results_drained();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("results never returned", 0, sb.pending());

      $display("covered %0d sample requests and %0d checked results over %0d settings",
               sb.noted, sb.checked, settings_applied);
      $display("incl. sag and over-discharge latch episodes, temperature bands, "
               , "invalid samples and a long result stall");
      if (sb.mismatches == 0) begin
         $display("[battery_guard_fault_latch] OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("[battery_guard_fault_latch] ERROR");
      end
      $finish;
   end

endmodule
